@@ rtl/core/kmp_pkg.sv @@
package kmp_pkg;

    localparam int MATCH_W = 32;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_TEXT    = 2'd3
    } kmp_cmd_t;

    localparam logic STATUS_MATCH = 1'b0;
    localparam logic STATUS_FULL  = 1'b1;

    typedef struct packed {
        kmp_cmd_t    cmd;
        logic [7:0]  char_in;
    } kmp_req_t;

    typedef struct packed {
        logic               status;
        logic [MATCH_W-1:0] match_start;
    } kmp_result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CMP,
        ST_FAIL_LD
    } kmp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_clear;
        logic do_restart;
        logic do_reject;
        logic do_append_first;
        logic do_pos_inc;
        logic do_load;
        logic load_build;
        logic do_step;
        logic do_build_done;
        logic do_match;
        logic do_text_done;
        logic do_fail_load;
    } kmp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic len_zero;
        logic len_full;
        logic eq;
        logic k_zero;
        logic hit;
    } kmp_stat_t;

endpackage

@@ rtl/core/kmp_ctrl.sv @@
module kmp_ctrl
    import kmp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  kmp_cmd_t  cmd,
    input  kmp_stat_t stat,
    output kmp_ctrl_t ctrl,
    output logic      busy
);

    kmp_state_t state_reg, state_next;
    logic       build_reg, build_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        build_next = build_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (cmd == CMD_APPEND && !stat.len_full && !stat.len_zero)
                    begin
                        state_next = ST_FETCH;
                        build_next = 1'b1;
                    end
                    else if (cmd == CMD_TEXT && !stat.len_zero)
                    begin
                        state_next = ST_FETCH;
                        build_next = 1'b0;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!stat.eq && !stat.k_zero)
                begin
                    state_next = ST_CMP;
                end
                else if (!build_reg && stat.hit)
                begin
                    state_next = ST_FAIL_LD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FAIL_LD:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        ctrl = '0;
        busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_CLEAR:
                        begin
                            ctrl.do_clear = 1'b1;
                        end
                        CMD_APPEND:
                        begin
                            if (stat.len_full)
                            begin
                                ctrl.do_reject = 1'b1;
                            end
                            else if (stat.len_zero)
                            begin
                                ctrl.do_append_first = 1'b1;
                            end
                            else
                            begin
                                ctrl.do_load    = 1'b1;
                                ctrl.load_build = 1'b1;
                            end
                        end
                        CMD_RESTART:
                        begin
                            ctrl.do_restart = 1'b1;
                        end
                        CMD_TEXT:
                        begin
                            if (stat.len_zero)
                            begin
                                ctrl.do_pos_inc = 1'b1;
                            end
                            else
                            begin
                                ctrl.do_load = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                ctrl = '0;
            end
            ST_CMP:
            begin
                if (!stat.eq && !stat.k_zero)
                begin
                    ctrl.do_step = 1'b1;
                end
                else if (build_reg)
                begin
                    ctrl.do_build_done = 1'b1;
                end
                else if (stat.hit)
                begin
                    ctrl.do_match = 1'b1;
                end
                else
                begin
                    ctrl.do_text_done = 1'b1;
                end
            end
            ST_FAIL_LD:
            begin
                ctrl.do_fail_load = 1'b1;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.do_clear, ctrl.do_restart, ctrl.do_reject, ctrl.do_append_first,
                  ctrl.do_pos_inc, ctrl.do_load, ctrl.do_step, ctrl.do_build_done,
                  ctrl.do_match, ctrl.do_text_done, ctrl.do_fail_load}))
        else $error("more than one datapath action in a cycle");

    a_fail_ld_after_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FAIL_LD) |-> $past(ctrl.do_match))
        else $error("failure link load without a preceding match");

    a_no_match_in_build: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.do_match |-> !build_reg)
        else $error("match reported while extending the pattern");

endmodule

@@ rtl/core/kmp_datapath.sv @@
module kmp_datapath
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  kmp_req_t    req,
    input  kmp_ctrl_t   ctrl,
    output kmp_stat_t   stat,
    output logic        result_valid,
    output kmp_result_t result
);

    localparam int ADDR_W = $clog2(MAX_PATTERN);
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int EXT_W  = (POSITION_BITS > MATCH_W) ? POSITION_BITS : MATCH_W;

    logic [7:0]        pat_mem  [MAX_PATTERN];
    logic [ADDR_W-1:0] fail_mem [MAX_PATTERN];

    logic [7:0]        pat_rdata;
    logic [ADDR_W-1:0] fail_rdata;
    logic [ADDR_W-1:0] pat_raddr, fail_raddr, waddr;
    logic [7:0]        pat_wdata;
    logic [ADDR_W-1:0] fail_wdata;
    logic              mem_we;

    logic [LEN_W-1:0]         len_reg, len_next;
    logic [ADDR_W-1:0]        build_reg, build_next;
    logic [ADDR_W-1:0]        matched_reg, matched_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     valid_reg, valid_next;
    kmp_result_t              result_reg, result_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic [7:0]               char_reg, char_next;

    logic [LEN_W-1:0]         k_adv;
    logic [ADDR_W-1:0]        k_start;
    logic [POSITION_BITS-1:0] start_pos;
    logic [EXT_W-1:0]         start_ext;

    // Status for the controller.
    always_comb
    begin
        k_adv         = LEN_W'(k_reg) + LEN_W'(pat_rdata == char_reg);
        stat.len_zero = (len_reg == '0);
        stat.len_full = (len_reg == LEN_W'(MAX_PATTERN));
        stat.eq       = (pat_rdata == char_reg);
        stat.k_zero   = (k_reg == '0);
        stat.hit      = (k_adv == len_reg);
    end

    // Memory addressing. A failure step reads straight from the link just fetched.
    always_comb
    begin
        pat_raddr  = ctrl.do_step ? fail_rdata : k_reg;
        fail_raddr = ctrl.do_match ? ADDR_W'(len_reg - LEN_W'(1)) : (pat_raddr - ADDR_W'(1));
        mem_we     = ctrl.do_append_first | ctrl.do_build_done;
        waddr      = len_reg[ADDR_W-1:0];
        pat_wdata  = ctrl.do_build_done ? char_reg : req.char_in;
        fail_wdata = ctrl.do_build_done ? k_adv[ADDR_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pat_mem[waddr]  <= pat_wdata;
            fail_mem[waddr] <= fail_wdata;
        end
        pat_rdata  <= pat_mem[pat_raddr];
        fail_rdata <= fail_mem[fail_raddr];
    end

    always_comb
    begin
        start_pos = pos_reg - POSITION_BITS'(len_reg) + POSITION_BITS'(1);
        start_ext = EXT_W'(start_pos);
        k_start   = (LEN_W'(matched_reg) >= len_reg) ? '0 : matched_reg;
    end

    always_comb
    begin
        len_next     = len_reg;
        build_next   = build_reg;
        matched_next = matched_reg;
        pos_next     = pos_reg;
        valid_next   = 1'b0;
        result_next  = result_reg;
        k_next       = k_reg;
        char_next    = char_reg;

        if (ctrl.do_clear)
        begin
            len_next     = '0;
            build_next   = '0;
            matched_next = '0;
        end
        if (ctrl.do_restart)
        begin
            pos_next     = '0;
            matched_next = '0;
        end
        if (ctrl.do_reject)
        begin
            valid_next              = 1'b1;
            result_next.status      = STATUS_FULL;
            result_next.match_start = '0;
        end
        if (ctrl.do_append_first)
        begin
            len_next     = LEN_W'(1);
            build_next   = '0;
            matched_next = '0;
        end
        if (ctrl.do_load)
        begin
            k_next    = ctrl.load_build ? build_reg : k_start;
            char_next = req.char_in;
        end
        if (ctrl.do_step)
        begin
            k_next = fail_rdata;
        end
        if (ctrl.do_build_done)
        begin
            len_next     = len_reg + LEN_W'(1);
            build_next   = k_adv[ADDR_W-1:0];
            matched_next = '0;
        end
        if (ctrl.do_match)
        begin
            valid_next              = 1'b1;
            result_next.status      = STATUS_MATCH;
            result_next.match_start = start_ext[MATCH_W-1:0];
        end
        if (ctrl.do_text_done)
        begin
            matched_next = k_adv[ADDR_W-1:0];
        end
        if (ctrl.do_fail_load)
        begin
            matched_next = fail_rdata;
        end
        if (ctrl.do_pos_inc || ctrl.do_text_done || ctrl.do_fail_load)
        begin
            pos_next = pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            build_reg   <= '0;
            matched_reg <= '0;
            pos_reg     <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            build_reg   <= build_next;
            matched_reg <= matched_next;
            pos_reg     <= pos_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        k_reg      <= k_next;
        char_reg   <= char_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(ctrl.do_reject || ctrl.do_match))
        else $error("result strobe without a reject or a match");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_matched_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (LEN_W'(matched_reg) < len_reg) || (matched_reg == '0))
        else $error("matched length not below pattern length");

endmodule

@@ rtl/core/kmp_stream_matcher.sv @@
// Clear, restart, a full-store reject, an append to an empty pattern and a text byte on
// an empty pattern are done without leaving idle. Any other append or text byte passes
// through the fetch state, then stays in compare for each failure link followed; a match
// adds the failure-link load state. Each link followed costs one memory read.
// Results appear in the cycle after the decision as a one-cycle strobe; they cannot stall.
// Reset clears lengths, match state and text position; pattern memory is not cleared.
module kmp_stream_matcher
    import kmp_pkg::*;
#(
    parameter int MAX_PATTERN   = 64,
    parameter int POSITION_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  kmp_req_t    req,
    output logic        result_valid,
    output kmp_result_t result
);

    kmp_ctrl_t ctrl;
    kmp_stat_t stat;

    kmp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (req.cmd),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    kmp_datapath #(
        .MAX_PATTERN   (MAX_PATTERN),
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .ctrl         (ctrl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
